// ===== hdl/ssfb_pkg.sv =====
// types, codes and constants shared by the seven-segment frame builder
// no dependencies; every other file but ssfb_ifc refers to it by scoped names
`default_nettype none

package ssfb_pkg;

	// request codes of the command word; code 7 is unused
	typedef enum logic [2:0] {
		REQ_INIT   = 3'd0,
		REQ_NUMBER = 3'd1,
		REQ_TEMP   = 3'd2,
		REQ_SCORE  = 3'd3,
		REQ_BRIGHT = 3'd4,
		REQ_BLINK  = 3'd5,
		REQ_CLEAR  = 3'd6
	} ssfb_req_t;

	// configuration register indexes
	localparam logic [1:0] REG_DATA_CMD = 2'd0;
	localparam logic [1:0] REG_ADDR_CMD = 2'd1;
	localparam logic [1:0] REG_DISP_CMD = 2'd2;

	// configuration reset values
	localparam logic [7:0] DATA_CMD_RST = 8'h40;
	localparam logic [7:0] ADDR_CMD_RST = 8'hC0;
	localparam logic [7:0] DISP_CMD_RST = 8'h88;

	// byte sequence kinds handed from front to back
	typedef enum logic [1:0] {
		KIND_INIT,
		KIND_FRAME,
		KIND_SCORE,
		KIND_SINGLE
	} ssfb_kind_t;

	// segment and control constants
	localparam logic [7:0]  SEG_BLANK   = 8'h00;
	localparam logic [7:0]  SEG_POINT   = 8'h80;
	localparam logic [7:0]  SEG_C       = 8'h39;
	localparam logic [7:0]  SEG_H       = 8'h76;
	localparam logic [7:0]  SEG_I       = 8'h06;
	localparam logic [7:0]  SEG_DASH    = 8'h40;
	localparam logic [7:0]  BRIGHT_BASE = 8'h88;
	localparam logic [7:0]  BLINK_CTRL  = 8'h89;
	localparam logic [2:0]  LEVEL_MAX   = 3'd7;
	localparam logic [13:0] VALUE_MAX   = 14'd9999;
	localparam logic [13:0] UNIT_1000   = 14'd1000;
	localparam logic [13:0] UNIT_100    = 14'd100;
	localparam logic [13:0] UNIT_10     = 14'd10;

	// last byte index of the init, frame and score kinds, and the first index of the second score frame
	localparam logic [3:0] LAST_INIT   = 4'd6;
	localparam logic [3:0] LAST_FRAME  = 4'd4;
	localparam logic [3:0] LAST_SCORE  = 4'd9;
	localparam logic [3:0] SCORE_FRAME2 = 4'd5;

	// configuration register set
	typedef struct packed {
		logic [7:0] data_cmd;
		logic [7:0] addr_cmd;
		logic [7:0] disp_cmd;
	} ssfb_cfg_t;

	// queue entry: one classified command with its prepared bytes
	typedef struct packed {
		ssfb_kind_t      kind;
		logic [3:0][7:0] seg;
		logic [7:0]      single;
	} ssfb_entry_t;

	// one decimal digit step: digit and what is left below the unit
	typedef struct packed {
		logic [3:0]  digit;
		logic [13:0] rem;
	} ssfb_digit_t;

	// segment pattern of a decimal digit
	function automatic logic [7:0] font(input logic [3:0] d);
		logic [7:0] r;
		case (d)
			4'd0: r = 8'h3F;
			4'd1: r = 8'h06;
			4'd2: r = 8'h5B;
			4'd3: r = 8'h4F;
			4'd4: r = 8'h66;
			4'd5: r = 8'h6D;
			4'd6: r = 8'h7D;
			4'd7: r = 8'h07;
			4'd8: r = 8'h7F;
			4'd9: r = 8'h6F;
			default: r = SEG_BLANK;
		endcase
		return r;
	endfunction

	// compare ladder against the unit multiples; v stays below ten units
	function automatic ssfb_digit_t digit_step(input logic [13:0] v, input logic [13:0] unit);
		ssfb_digit_t r;
		r.digit = 4'd0;
		for (int i = 1; i < 10; i++) begin
			if (v >= 14'(i) * unit)
				r.digit = 4'(i);
		end
		r.rem = v - 14'(r.digit) * unit;
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/ssfb_ifc.sv =====
// valid/ready channel interfaces of the seven-segment frame builder
// command word in, display byte out; no dependencies
`default_nettype none

interface ssfb_cmd_if;
	logic        valid;
	logic        ready;
	logic [2:0]  req_type;
	logic [15:0] value;
	logic        show_zeros;
	logic [7:0]  level;
	logic        blink_on;

	modport source(output valid, output req_type, output value, output show_zeros,
		output level, output blink_on, input ready);
	modport sink(input valid, input req_type, input value, input show_zeros,
		input level, input blink_on, output ready);
endinterface

interface ssfb_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_out;
	logic       frame_first;
	logic       frame_last;
	logic       last;

	modport source(output valid, output byte_out, output frame_first, output frame_last,
		output last, input ready);
	modport sink(input valid, input byte_out, input frame_first, input frame_last,
		input last, output ready);
endinterface

`default_nettype wire

// ===== hdl/seven_segment_frame_builder.sv =====
// channel  | role   | handshake   | word
// cmd      | sink   | valid/ready | one display command
// disp     | source | valid/ready | one controller byte with start/stop marks
// cfg      | write  | cfg_wr_en   | one 8-bit register, index 0..2
//
// a command has 1, 5, 7 or 10 bytes, which the byte sequencer sends one byte per
// cycle while disp is ready; after the accept edge the first byte passes through
// the three digit stages, the queue and the output register. reset clears all
// valid bits and loads the register defaults; no clearing pass. a stalled disp
// holds the output register while cmd keeps flowing until the QUEUE_DEPTH
// entries and the three front stages fill.
//
// top level of the seven-segment frame builder; uses ssfb_pkg, ssfb_ifc,
// ssfb_front, ssfb_queue and ssfb_back
`default_nettype none

module seven_segment_frame_builder #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_wr_en,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data,
	ssfb_cmd_if.sink        cmd,
	ssfb_byte_if.source     disp
);

	ssfb_pkg::ssfb_cfg_t   cfg_q;
	logic                  q_wr_valid, q_wr_ready;
	logic                  q_rd_valid, q_pop;
	ssfb_pkg::ssfb_entry_t q_wr_data, q_rd_data;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.data_cmd <= ssfb_pkg::DATA_CMD_RST;
			cfg_q.addr_cmd <= ssfb_pkg::ADDR_CMD_RST;
			cfg_q.disp_cmd <= ssfb_pkg::DISP_CMD_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				ssfb_pkg::REG_DATA_CMD: cfg_q.data_cmd <= cfg_data;
				ssfb_pkg::REG_ADDR_CMD: cfg_q.addr_cmd <= cfg_data;
				ssfb_pkg::REG_DISP_CMD: cfg_q.disp_cmd <= cfg_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	ssfb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.disp_cmd (cfg_q.disp_cmd),
		.q_valid  (q_wr_valid),
		.q_ready  (q_wr_ready),
		.q_data   (q_wr_data)
	);

	ssfb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (q_wr_valid),
		.wr_ready (q_wr_ready),
		.wr_data  (q_wr_data),
		.rd_valid (q_rd_valid),
		.rd_pop   (q_pop),
		.rd_data  (q_rd_data)
	);

	ssfb_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_valid (q_rd_valid),
		.q_pop   (q_pop),
		.q_data  (q_rd_data),
		.disp    (disp)
	);

`ifndef SYNTHESIS
	// every command ends with a stop condition
	a_last_has_stop: assert property (@(posedge clk) disable iff (!arst_n)
		disp.valid && disp.last |-> disp.frame_last)
		else $error("final byte of a command without stop");

	// the sequencer only retires an entry that is present
	a_pop_has_entry: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_rd_valid)
		else $error("queue pop while empty");

	// a byte opening a frame never follows a byte that did not close one
	a_start_after_stop: assert property (@(posedge clk) disable iff (!arst_n)
		disp.valid && disp.ready && !disp.frame_last |=> !(disp.valid && disp.frame_first))
		else $error("start condition inside an open frame");
`endif

endmodule

`default_nettype wire

// ===== hdl/ssfb_front.sv =====
// front end: accepts commands, splits the value into decimal digits over
// three stages and classifies each command into a queue entry; uses ssfb_pkg
`default_nettype none

module ssfb_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	ssfb_cmd_if.sink                  cmd,
	input  wire logic [7:0]           disp_cmd,
	output      logic                 q_valid,
	input  wire logic                 q_ready,
	output      ssfb_pkg::ssfb_entry_t q_data
);

	logic        vld_s1, vld_s2, vld_s3;
	logic [2:0]  req_s1, req_s2, req_s3;
	logic        lz_s1, lz_s2, lz_s3;
	logic [2:0]  lvl_s1, lvl_s2, lvl_s3;
	logic        blink_s1, blink_s2, blink_s3;
	logic [13:0] val_s1;
	logic [3:0]  d0_s2, d0_s3, d1_s3;
	logic [13:0] rem_s2, rem_s3;

	logic        en;
	logic        push_req;
	logic [13:0] val_in;
	logic [2:0]  lvl_in;
	ssfb_pkg::ssfb_digit_t st0, st1, st2;
	logic [3:0]  d2, d3;
	logic        show0, show1, show2;

	// the whole pipeline moves unless a finished entry waits on a full queue
	assign push_req  = vld_s3 && (req_s3 != 3'(ssfb_pkg::REQ_CLEAR + 3'd1));
	assign en        = !push_req || q_ready;
	assign cmd.ready = en;
	assign q_valid   = push_req;

	// operand selection and saturation
	always_comb begin
		if (cmd.req_type == ssfb_pkg::REQ_TEMP)
			val_in = {6'd0, cmd.value[7:0]};
		else if (cmd.value > 16'(ssfb_pkg::VALUE_MAX))
			val_in = ssfb_pkg::VALUE_MAX;
		else
			val_in = cmd.value[13:0];
		lvl_in = (cmd.level > 8'(ssfb_pkg::LEVEL_MAX)) ? ssfb_pkg::LEVEL_MAX : cmd.level[2:0];
	end

	// one decimal digit step per stage; the last step also leaves the units digit
	assign st0 = ssfb_pkg::digit_step(val_s1, ssfb_pkg::UNIT_1000);
	assign st1 = ssfb_pkg::digit_step(rem_s2, ssfb_pkg::UNIT_100);
	assign st2 = ssfb_pkg::digit_step(rem_s3, ssfb_pkg::UNIT_10);
	assign d2  = st2.digit;
	assign d3  = st2.rem[3:0];

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= cmd.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (en) begin
			req_s1   <= cmd.req_type;
			lz_s1    <= cmd.show_zeros;
			lvl_s1   <= lvl_in;
			blink_s1 <= cmd.blink_on;
			val_s1   <= val_in;

			req_s2   <= req_s1;
			lz_s2    <= lz_s1;
			lvl_s2   <= lvl_s1;
			blink_s2 <= blink_s1;
			d0_s2    <= st0.digit;
			rem_s2   <= st0.rem;

			req_s3   <= req_s2;
			lz_s3    <= lz_s2;
			lvl_s3   <= lvl_s2;
			blink_s3 <= blink_s2;
			d0_s3    <= d0_s2;
			d1_s3    <= st1.digit;
			rem_s3   <= st1.rem;
		end
	end

	// zero blanking chain
	assign show0 = lz_s3 || (d0_s3 != 4'd0);
	assign show1 = show0 || (d1_s3 != 4'd0);
	assign show2 = show1 || (d2 != 4'd0);

	// classify and prepare the bytes of the entry
	always_comb begin
		q_data.kind   = ssfb_pkg::KIND_FRAME;
		q_data.seg    = {4{ssfb_pkg::SEG_BLANK}};
		q_data.single = ssfb_pkg::SEG_BLANK;
		case (req_s3)
			ssfb_pkg::REQ_INIT: begin
				q_data.kind = ssfb_pkg::KIND_INIT;
			end
			ssfb_pkg::REQ_NUMBER: begin
				q_data.seg[0] = show0 ? ssfb_pkg::font(d0_s3) : ssfb_pkg::SEG_BLANK;
				q_data.seg[1] = show1 ? ssfb_pkg::font(d1_s3) : ssfb_pkg::SEG_BLANK;
				q_data.seg[2] = show2 ? ssfb_pkg::font(d2) : ssfb_pkg::SEG_BLANK;
				q_data.seg[3] = ssfb_pkg::font(d3);
			end
			ssfb_pkg::REQ_TEMP: begin
				q_data.seg[0] = ssfb_pkg::font(d2);
				q_data.seg[1] = ssfb_pkg::font(d3) | ssfb_pkg::SEG_POINT;
				q_data.seg[2] = ssfb_pkg::SEG_C;
				q_data.seg[3] = ssfb_pkg::SEG_BLANK;
			end
			ssfb_pkg::REQ_SCORE: begin
				q_data.kind   = ssfb_pkg::KIND_SCORE;
				q_data.seg[0] = ssfb_pkg::font(d0_s3);
				q_data.seg[1] = ssfb_pkg::font(d1_s3);
				q_data.seg[2] = ssfb_pkg::font(d2);
				q_data.seg[3] = ssfb_pkg::font(d3);
			end
			ssfb_pkg::REQ_BRIGHT: begin
				q_data.kind   = ssfb_pkg::KIND_SINGLE;
				q_data.single = ssfb_pkg::BRIGHT_BASE | {5'd0, lvl_s3};
			end
			ssfb_pkg::REQ_BLINK: begin
				q_data.kind   = ssfb_pkg::KIND_SINGLE;
				q_data.single = blink_s3 ? ssfb_pkg::BLINK_CTRL : disp_cmd;
			end
			ssfb_pkg::REQ_CLEAR: begin
				q_data.kind = ssfb_pkg::KIND_FRAME;
			end
			default: begin
				q_data.kind = ssfb_pkg::KIND_FRAME;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hdl/ssfb_queue.sv =====
// short entry queue between the front end and the byte sequencer
// register file with wrap-around pointers and a fill count; uses ssfb_pkg
`default_nettype none

module ssfb_queue #(
	parameter int DEPTH = 2
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  wr_valid,
	output      logic                  wr_ready,
	input  wire ssfb_pkg::ssfb_entry_t wr_data,
	output      logic                  rd_valid,
	input  wire logic                  rd_pop,
	output      ssfb_pkg::ssfb_entry_t rd_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	ssfb_pkg::ssfb_entry_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push, pop;

	assign wr_ready = (count_q != CW'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_pop && rd_valid;
	assign rd_data  = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_data;
	end

endmodule

`default_nettype wire

// ===== hdl/ssfb_back.sv =====
// byte sequencer: walks one queue entry byte by byte into the output register
// marks start, stop and the final byte of each command; uses ssfb_pkg
`default_nettype none

module ssfb_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire ssfb_pkg::ssfb_cfg_t   cfg,
	input  wire logic                  q_valid,
	output      logic                  q_pop,
	input  wire ssfb_pkg::ssfb_entry_t q_data,
	ssfb_byte_if.source                disp
);

	logic [3:0] cnt_q;
	logic       vld_q;
	logic [7:0] byte_q;
	logic       first_q, stop_q, last_q;

	logic       load;
	logic [7:0] b;
	logic       ff, fl, fin;
	logic [3:0] idx_frame, idx_score;

	assign load  = !vld_q || disp.ready;
	assign q_pop = load && q_valid && fin;

	assign idx_frame = cnt_q - 4'd1;
	assign idx_score = cnt_q - 4'd6;

	// byte for the current position in the entry
	always_comb begin
		b   = ssfb_pkg::SEG_BLANK;
		ff  = 1'b0;
		fl  = 1'b0;
		fin = 1'b0;
		case (q_data.kind)
			ssfb_pkg::KIND_INIT: begin
				case (cnt_q)
					4'd0: begin
						b  = cfg.data_cmd;
						ff = 1'b1;
						fl = 1'b1;
					end
					4'd1: begin
						b  = cfg.disp_cmd;
						ff = 1'b1;
						fl = 1'b1;
					end
					4'd2: begin
						b  = cfg.addr_cmd;
						ff = 1'b1;
					end
					ssfb_pkg::LAST_INIT: begin
						fl  = 1'b1;
						fin = 1'b1;
					end
					default: b = ssfb_pkg::SEG_BLANK;
				endcase
			end
			ssfb_pkg::KIND_FRAME: begin
				if (cnt_q == 4'd0) begin
					b  = cfg.addr_cmd;
					ff = 1'b1;
				end else begin
					b = q_data.seg[idx_frame[1:0]];
				end
				fl  = (cnt_q == ssfb_pkg::LAST_FRAME);
				fin = fl;
			end
			ssfb_pkg::KIND_SCORE: begin
				case (cnt_q)
					4'd0, ssfb_pkg::SCORE_FRAME2: begin
						b  = cfg.addr_cmd;
						ff = 1'b1;
					end
					4'd1: b = ssfb_pkg::SEG_H;
					4'd2: b = ssfb_pkg::SEG_I;
					4'd3: b = ssfb_pkg::SEG_DASH;
					4'd4: begin
						b  = ssfb_pkg::SEG_DASH;
						fl = 1'b1;
					end
					ssfb_pkg::LAST_SCORE: begin
						b   = q_data.seg[idx_score[1:0]];
						fl  = 1'b1;
						fin = 1'b1;
					end
					default: b = q_data.seg[idx_score[1:0]];
				endcase
			end
			ssfb_pkg::KIND_SINGLE: begin
				b   = q_data.single;
				ff  = 1'b1;
				fl  = 1'b1;
				fin = 1'b1;
			end
			default: begin
				fin = 1'b1;
			end
		endcase
	end

	// position counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			cnt_q <= 4'd0;
		end else if (load) begin
			vld_q <= q_valid;
			if (q_valid)
				cnt_q <= fin ? 4'd0 : cnt_q + 4'd1;
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (load && q_valid) begin
			byte_q  <= b;
			first_q <= ff;
			stop_q  <= fl;
			last_q  <= fin;
		end
	end

	assign disp.valid       = vld_q;
	assign disp.byte_out    = byte_q;
	assign disp.frame_first = first_q;
	assign disp.frame_last  = stop_q;
	assign disp.last        = last_q;

endmodule

`default_nettype wire
